// ----- hdl/hbd_pkg.sv -----
`default_nettype none
package hbd_pkg;
  localparam int COUNT_BITS  = 20;
  localparam int PROD_BITS   = 2 * COUNT_BITS;
  localparam int SUM_BITS    = 31;
  localparam int GSUM_BITS   = 39;
  localparam int G_BITS      = 28;
  localparam int DIST_BITS   = 17;
  localparam int NUM_BITS    = 48;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;
  localparam int SQRT_STEPS  = 32;
  localparam int DIV_STEPS   = 48;
  localparam logic [DIST_BITS-1:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic [COUNT_BITS-1:0] a;
    logic [COUNT_BITS-1:0] b;
    logic [PROD_BITS-1:0]  prod;
    logic                  last;
  } entry_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_GSQ  = 7'b0000010,
    S_ACC  = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_RSQ  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;
endpackage
`default_nettype wire

// ----- hdl/hbd_fifo.sv -----
`default_nettype none
module hbd_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire hbd_pkg::entry_t wdata,
  input  wire logic           pop,
  output hbd_pkg::entry_t     rdata,
  output logic                full,
  output logic                empty
);
  import hbd_pkg::*;

  entry_t mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic [FIFO_AW:0]   count;

  assign full  = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/hbd_front.sv -----
`default_nettype none
module hbd_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [hbd_pkg::COUNT_BITS-1:0] bin_a,
  input  wire logic [hbd_pkg::COUNT_BITS-1:0] bin_b,
  input  wire logic                          last_bin,
  input  wire logic                          fifo_full,
  output logic                               push,
  output hbd_pkg::entry_t                    wdata
);
  import hbd_pkg::*;

  logic pvalid;

  assign in_stall = pvalid && fifo_full;
  assign push     = pvalid && !fifo_full;

  // bin product stage
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      wdata.a    <= bin_a;
      wdata.b    <= bin_b;
      wdata.prod <= PROD_BITS'(bin_a) * PROD_BITS'(bin_b);
      wdata.last <= last_bin;
    end
    if (rst) begin
      pvalid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      pvalid <= 1'b1;
    end else if (push) begin
      pvalid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/hbd_back.sv -----
`default_nettype none
module hbd_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire hbd_pkg::entry_t              rdata,
  input  wire logic                         fifo_empty,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [hbd_pkg::DIST_BITS-1:0]     distance,
  output logic                              empty_histogram
);
  import hbd_pkg::*;

  state_t state;
  logic [63:0] v;
  logic [63:0] bitv;
  logic [63:0] r;
  logic [5:0]  cnt;
  logic        last_q;
  logic        emp;
  logic [SUM_BITS-1:0]  sum_first;
  logic [SUM_BITS-1:0]  sum_second;
  logic [GSUM_BITS-1:0] sum_geometric;
  logic [NUM_BITS-1:0]  dnum;
  logic [30:0]          den;
  logic [30:0]          drem;

  logic [63:0] t;
  logic        ge;
  logic [SUM_BITS:0]   sa;
  logic [SUM_BITS:0]   sb;
  logic [GSUM_BITS:0]  sg;
  logic [2*SUM_BITS-1:0] sprod;
  logic [31:0]         rem_sh;
  logic                qbit;
  logic [DIST_BITS-1:0] res;
  logic                take;

  assign t      = r + bitv;
  assign ge     = (v >= t);
  assign sa     = {1'b0, sum_first} + (SUM_BITS+1)'(rdata.a);
  assign sb     = {1'b0, sum_second} + (SUM_BITS+1)'(rdata.b);
  assign sg     = {1'b0, sum_geometric} + (GSUM_BITS+1)'(r[G_BITS-1:0]);
  assign sprod  = (2*SUM_BITS)'(sum_first) * (2*SUM_BITS)'(sum_second);
  assign rem_sh = {drem, dnum[NUM_BITS-1]};
  assign qbit   = (rem_sh >= {1'b0, den});
  assign res    = emp ? ONE_Q16 :
                  (dnum > NUM_BITS'(ONE_Q16)) ? '0 : ONE_Q16 - dnum[DIST_BITS-1:0];
  assign take   = !out_valid || !out_stall;
  assign pop    = (state == S_IDLE) && !fifo_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      sum_first <= '0;
      sum_second <= '0;
      sum_geometric <= '0;
    end else begin
      if (state == S_FIN && take) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!fifo_empty) begin
            v          <= {8'b0, rdata.prod, 16'b0};
            r          <= '0;
            bitv       <= 64'h4000_0000_0000_0000;
            cnt        <= '0;
            last_q     <= rdata.last;
            sum_first  <= sa[SUM_BITS] ? '1 : sa[SUM_BITS-1:0];
            sum_second <= sb[SUM_BITS] ? '1 : sb[SUM_BITS-1:0];
            state      <= S_GSQ;
          end
        end
        S_GSQ, S_RSQ: begin
          if (ge) begin
            v <= v - t;
            r <= (r >> 1) + bitv;
          end else begin
            r <= r >> 1;
          end
          bitv <= bitv >> 2;
          if (cnt == 6'(SQRT_STEPS - 1)) begin
            state <= (state == S_GSQ) ? S_ACC : S_DIV;
            cnt   <= '0;
          end else begin
            cnt   <= cnt + 1'b1;
          end
        end
        S_ACC: begin
          sum_geometric <= sg[GSUM_BITS] ? '1 : sg[GSUM_BITS-1:0];
          state <= last_q ? S_MUL : S_IDLE;
        end
        S_MUL: begin
          if (sum_first == '0 || sum_second == '0) begin
            emp   <= 1'b1;
            state <= S_FIN;
          end else begin
            emp   <= 1'b0;
            v     <= 64'(sprod);
            r     <= '0;
            bitv  <= 64'h4000_0000_0000_0000;
            cnt   <= '0;
            state <= S_RSQ;
          end
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == '0) begin
            den  <= r[30:0];
            drem <= '0;
            dnum <= NUM_BITS'({sum_geometric, 8'b0}) + NUM_BITS'(r[31:1]);
          end else begin
            drem <= qbit ? 31'(rem_sh - {1'b0, den}) : rem_sh[30:0];
            dnum <= {dnum[NUM_BITS-2:0], qbit};
            if (cnt == 6'(DIV_STEPS)) state <= S_FIN;
          end
        end
        S_FIN: begin
          if (take) begin
            distance        <= res;
            empty_histogram <= emp;
            sum_first       <= '0;
            sum_second      <= '0;
            sum_geometric   <= '0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hdl/histogram_bhattacharyya_distance.sv -----
// the back end takes one queued bin at a time, while idle, through a one-bit-per-step
// square root; after the last bin it adds a second square root and the 48-step divide
// of the final ratio, both skipped when a sum is zero; the front stage and queue hold
// further bins and stall the input when full
// reset: rst, synchronous, active high, clears the sums, queue and valid flags
`default_nettype none
module histogram_bhattacharyya_distance (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [hbd_pkg::COUNT_BITS-1:0] bin_a,
  input  wire logic [hbd_pkg::COUNT_BITS-1:0] bin_b,
  input  wire logic        last_bin,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [hbd_pkg::DIST_BITS-1:0] distance,
  output logic             empty_histogram
);
  import hbd_pkg::*;

  entry_t wdata;
  entry_t rdata;
  logic   push;
  logic   pop;
  logic   full;
  logic   fempty;

  hbd_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .bin_a(bin_a), .bin_b(bin_b), .last_bin(last_bin),
    .fifo_full(full), .push(push), .wdata(wdata)
  );

  hbd_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .wdata(wdata), .pop(pop),
    .rdata(rdata), .full(full), .empty(fempty)
  );

  hbd_back u_back (
    .clk(clk), .rst(rst), .rdata(rdata), .fifo_empty(fempty), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .distance(distance),
    .empty_histogram(empty_histogram)
  );

`ifndef ASSERT_OFF
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> distance <= ONE_Q16) else $error("distance above one");
  a_empty_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_histogram |-> distance == ONE_Q16) else $error("empty not one");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(full && push && !pop)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(fempty && pop)) else $error("queue underflow");
`endif
endmodule
`default_nettype wire
